/* design/swm_pkg.sv */
// Shared types and constants of the sliding-window median filter.
`timescale 1ns / 1ps

package swm_pkg;

    // Field widths
    localparam int SAMPLE_W        = 32;
    localparam int MEDIAN_W        = 33;
    localparam int CFG_W           = 7;
    localparam int M_TDATA_W       = ((MEDIAN_W + 7) / 8) * 8;

    // Window defaults
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int WINDOW_SIZE_RST = 3;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] val;   // stored value
        logic                       vld;   // entry in use (cleared view during a restart)
        logic                       le;    // value is less than or equal to the new sample
        logic                       eqd;   // value equals the sample that leaves
        logic                       below; // entry sits below the entry that leaves
    } swm_link_t;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic step;   // a sample transfer updates the row
        logic drop;   // the window is full, the oldest sample leaves
        logic flush;  // the row is treated as empty before the insert
        logic clear;  // the window is emptied by a configuration write
    } swm_ctl_t;

    // Tie-offs at the two ends of the row
    localparam swm_link_t LINK_BOTTOM = '{val: '0, vld: 1'b1, le: 1'b1, eqd: 1'b0, below: 1'b1};
    localparam swm_link_t LINK_TOP    = '{val: '0, vld: 1'b0, le: 1'b0, eqd: 1'b0, below: 1'b0};

endpackage

/* design/swm_cell.sv */
// One cell of the sorted row: holds one window entry and shifts with its neighbors.
`timescale 1ns / 1ps

module swm_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swm_pkg::swm_ctl_t                  ctl,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] leaving,
    input  swm_pkg::swm_link_t                 lower,
    input  swm_pkg::swm_link_t                 upper,
    output swm_pkg::swm_link_t                 link
);
    import swm_pkg::*;

    logic signed [SAMPLE_W-1:0] val_reg;
    logic signed [SAMPLE_W-1:0] val_next;
    logic                       vld_reg;
    logic                       vld_next;

    logic      vld_eff;
    logic      le;
    logic      eqd;
    logic      lt;
    logic      del;
    logic      below;
    swm_link_t own;
    swm_link_t cur;
    swm_link_t prv;

    // Local compares against the new sample and the leaving sample.
    assign vld_eff = vld_reg && !ctl.flush;
    assign le      = vld_eff && (val_reg <= sample);
    assign eqd     = vld_eff && (val_reg == leaving);
    assign lt      = vld_eff && (val_reg < leaving);
    // Among equal entries the topmost one leaves, so the choice is local.
    assign del     = eqd && !upper.eqd;
    assign below   = lt || (eqd && !del);

    assign own  = '{val: val_reg, vld: vld_eff, le: le, eqd: eqd, below: below};
    assign link = own;

    // Entry at this place and the one under it once the leaving entry is gone.
    always_comb
    begin
        cur = (ctl.drop && !below) ? upper : own;
        prv = (ctl.drop && !lower.below) ? own : lower;
    end

    // Insert the new sample after all entries that are not greater.
    always_comb
    begin
        if (cur.le)
        begin
            val_next = cur.val;
            vld_next = cur.vld;
        end
        else if (prv.le)
        begin
            val_next = sample;
            vld_next = 1'b1;
        end
        else
        begin
            val_next = prv.val;
            vld_next = prv.vld;
        end
    end

    // Entry flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            vld_reg <= vld_next;
        end
    end

    // Entry value.
    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            val_reg <= val_next;
        end
    end

endmodule

/* design/swm_history.sv */
// Arrival-order store of the window samples with a registered read port.
`timescale 1ns / 1ps

module swm_history #(
    parameter  int DEPTH  = swm_pkg::WINDOW_MAX_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [swm_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [swm_pkg::SAMPLE_W-1:0] rd_data
);
    import swm_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a write to the same slot is passed through.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/sliding_window_median.sv */
// Top level of the sliding-window median filter: control, sorted cell row and output stage.
//
//  Channel  | Ports                          | Contents
//  ---------+--------------------------------+-------------------------------------------
//  input    | s_tvalid s_tready s_tdata      | tdata[31:0] sample; tuser start_req
//  output   | m_tvalid m_tready m_tdata      | tdata[32:0] median_twice, [39:33] zero
//  config   | cfg_wr_en cfg_wr_data          | window_size, 7 bits
//
// One sample is taken per clock while not stalled; the row of sorting cells
// removes the oldest entry and inserts the new one in the cycle of the transfer.
// The result is selected from the row and registered at the output. The input
// stalls only while a result waits in the output register and the next one is
// pending. Reset and configuration writes empty the window at once, with no sweep.
`timescale 1ns / 1ps

module sliding_window_median #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample (bits 31:0)
    input  logic [swm_pkg::SAMPLE_W-1:0]  s_tdata,
    // start_req
    input  logic                          s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // median_twice (bits 32:0), zero fill above
    output logic [swm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]     cfg_wr_data
);
    import swm_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int W_RST  = (WINDOW_MAX < WINDOW_SIZE_RST) ? WINDOW_MAX : WINDOW_SIZE_RST;

    logic [CNT_W-1:0]    eff_w_reg;
    logic [CNT_W-1:0]    eff_w_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [SLOT_W-1:0]   oldest_reg;
    logic [SLOT_W-1:0]   oldest_next;
    logic                pend_reg;
    logic                m_valid_reg;
    logic [MEDIAN_W-1:0] m_data_reg;

    logic                accept;
    logic                out_ok;
    logic                full;
    logic                result_due;
    logic [31:0]         cfg_ext;
    logic [SLOT_W-1:0]   wr_addr;
    logic [SLOT_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] leaving;
    swm_ctl_t            ctl;

    swm_link_t           link      [WINDOW_MAX];
    swm_link_t           lower_lnk [WINDOW_MAX];
    swm_link_t           upper_lnk [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] vld_vec;

    logic [SLOT_W-1:0]          lo_idx;
    logic [SLOT_W-1:0]          hi_idx;
    logic signed [SAMPLE_W-1:0] lo_val;
    logic signed [SAMPLE_W-1:0] hi_val;
    logic [MEDIAN_W-1:0]        sum;

    // Handshake.
    assign out_ok   = !m_valid_reg || m_tready;
    assign s_tready = !pend_reg || out_ok;
    assign accept   = s_tvalid && s_tready;

    // Effective window length from a configuration write.
    assign cfg_ext = 32'(cfg_wr_data);
    always_comb
    begin
        if (cfg_ext == 32'd0)
        begin
            eff_w_next = CNT_W'(1);
        end
        else if (cfg_ext > 32'(WINDOW_MAX))
        begin
            eff_w_next = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_w_next = CNT_W'(cfg_ext);
        end
    end

    // Window bookkeeping for the sample in transfer.
    always_comb
    begin
        full        = !s_tuser && (fill_reg >= eff_w_reg);
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        wr_addr     = '0;
        if (s_tuser)
        begin
            fill_next   = CNT_W'(1);
            oldest_next = '0;
        end
        else if (full)
        begin
            wr_addr = oldest_reg;
            if (CNT_W'(oldest_reg) + CNT_W'(1) == eff_w_reg)
            begin
                oldest_next = '0;
            end
            else
            begin
                oldest_next = oldest_reg + SLOT_W'(1);
            end
        end
        else
        begin
            wr_addr   = fill_reg[SLOT_W-1:0];
            fill_next = fill_reg + CNT_W'(1);
        end
        result_due = (fill_next == eff_w_reg);
        rd_addr    = accept ? oldest_next : oldest_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg  <= CNT_W'(W_RST);
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            eff_w_reg  <= eff_w_next;
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
        end
    end

    // Arrival-order store; the read tracks the next sample to leave.
    swm_history #(
        .DEPTH (WINDOW_MAX)
    ) u_history (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (leaving)
    );

    // Row of sorting cells.
    assign ctl = '{step: accept, drop: accept && full, flush: accept && s_tuser,
                   clear: cfg_wr_en};

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        if (i == 0)
        begin : g_bottom
            assign lower_lnk[i] = LINK_BOTTOM;
        end
        else
        begin : g_mid_lo
            assign lower_lnk[i] = link[i-1];
        end
        if (i == WINDOW_MAX - 1)
        begin : g_top
            assign upper_lnk[i] = LINK_TOP;
        end
        else
        begin : g_mid_hi
            assign upper_lnk[i] = link[i+1];
        end

        swm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .sample  ($signed(s_tdata)),
            .leaving ($signed(leaving)),
            .lower   (lower_lnk[i]),
            .upper   (upper_lnk[i]),
            .link    (link[i])
        );

        assign vld_vec[i] = link[i].vld;
    end

    // Select the two middle entries; they coincide for an odd window.
    assign lo_idx = SLOT_W'((eff_w_reg - CNT_W'(1)) >> 1);
    assign hi_idx = SLOT_W'(eff_w_reg >> 1);

    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (SLOT_W'(i) == lo_idx)
            begin
                lo_val = lo_val | link[i].val;
            end
            if (SLOT_W'(i) == hi_idx)
            begin
                hi_val = hi_val | link[i].val;
            end
        end
    end

    assign sum = MEDIAN_W'({lo_val[SAMPLE_W-1], lo_val}) + MEDIAN_W'({hi_val[SAMPLE_W-1], hi_val});

    // Pending result and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_reg <= result_due;
            end
            else if (out_ok)
            begin
                pend_reg <= 1'b0;
            end
            if (out_ok)
            begin
                m_valid_reg <= pend_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ok && pend_reg)
        begin
            m_data_reg <= sum;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

    // The entries in use form a contiguous run from the bottom of the row.
    a_vld_contig : assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.flush |-> ((vld_vec & (vld_vec + WINDOW_MAX'(1))) == '0))
        else $error("sorted row has a gap");

    // The number of entries in use matches the fill count.
    a_fill_count : assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.flush |-> ($countones(vld_vec) == int'(fill_reg)))
        else $error("fill count does not match the row");

    // The fill count never exceeds the window and the oldest slot lies inside it.
    a_fill_range : assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= eff_w_reg) && (CNT_W'(oldest_reg) < eff_w_reg))
        else $error("window bookkeeping out of range");

endmodule

/* tb/median_checker.sv */
// Stream checker for the sliding-window median filter: window predictor and result compare.
`timescale 1ns / 1ps

module median_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample (bits 31:0)
    input  logic [swm_pkg::SAMPLE_W-1:0]   s_tdata,
    // start_req
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // median_twice (bits 32:0), zero fill above
    input  logic [swm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]      cfg_wr_data,
    output int                             fail_count,
    output int                             pending_count
);
    import swm_pkg::*;

    localparam int WIN_LIMIT   = WINDOW_MAX_DEF;

    // Predicted window: samples by arrival slot and the same samples in ascending order.
    logic [CFG_W-1:0]           win_size_reg;
    logic signed [SAMPLE_W-1:0] arrival_ring [WIN_LIMIT];
    logic signed [SAMPLE_W-1:0] ranked_q [$];
    int unsigned                oldest_idx;

    // Medians still owed by the block, oldest first.
    logic signed [MEDIAN_W-1:0] median_q [$];

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        win_size_reg  = CFG_W'(WINDOW_SIZE_RST);
        oldest_idx    = 0;
    end

    // A register value of zero acts as one; anything above the row length saturates.
    function automatic int unsigned active_width();
        if (win_size_reg == 0)
            return 1;
        if (win_size_reg > WIN_LIMIT)
            return WIN_LIMIT;
        return 32'(win_size_reg);
    endfunction

    function automatic void empty_window();
        ranked_q.delete();
        oldest_idx = 0;
    endfunction

    // Duplicates are allowed, so exactly one equal entry leaves.
    function automatic void drop_ranked(input logic signed [SAMPLE_W-1:0] v);
        foreach (ranked_q[k])
        begin
            if (ranked_q[k] == v)
            begin
                ranked_q.delete(k);
                return;
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Apply one sample transfer to the predicted window and queue its median once full.
    task automatic take_sample(input logic signed [SAMPLE_W-1:0] smp, input logic restart);
        int unsigned                w;
        int unsigned                slot;
        int                         pos;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        w = active_width();
        if (restart)
            empty_window();
        if (ranked_q.size() >= w)
        begin
            slot = oldest_idx % w;
            drop_ranked(arrival_ring[slot]);
            arrival_ring[slot] = smp;
            oldest_idx = (slot + 1) % w;
        end
        else
        begin
            arrival_ring[ranked_q.size()] = smp;
        end
        pos = 0;
        while (pos < ranked_q.size() && ranked_q[pos] <= smp)
            pos++;
        ranked_q.insert(pos, smp);
        if (ranked_q.size() >= w)
        begin
            // For odd widths both picks are the middle entry.
            lo = ranked_q[(w - 1) / 2];
            hi = ranked_q[w / 2];
            median_q.push_back({lo[SAMPLE_W-1], lo} + {hi[SAMPLE_W-1], hi});
        end
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        logic signed [MEDIAN_W-1:0] want;
        if (median_q.size() == 0)
        begin
            report_mismatch($sformatf("result %0d with no median owed",
                                      $signed(word[MEDIAN_W-1:0])));
            return;
        end
        want = median_q.pop_front();
        if (word[MEDIAN_W-1:0] !== want)
            report_mismatch($sformatf("median_twice got %0d, expected %0d",
                                      $signed(word[MEDIAN_W-1:0]), want));
        if (word[M_TDATA_W-1:MEDIAN_W] !== '0)
            report_mismatch($sformatf("tdata fill bits got %h, expected zero",
                                      word[M_TDATA_W-1:MEDIAN_W]));
    endtask

    // Watch configuration, input and output transfers at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg = CFG_W'(WINDOW_SIZE_RST);
            empty_window();
            median_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                win_size_reg = cfg_wr_data;
                empty_window();
            end
            if (s_tvalid && s_tready)
                take_sample($signed(s_tdata), s_tuser);
            if (m_tvalid && m_tready)
                check_result(m_tdata);
        end
        pending_count = median_q.size();
    end

endmodule

/* tb/sliding_window_median_tb.sv */
// Testbench top of the sliding-window median filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sliding_window_median_tb;

    import swm_pkg::*;

    localparam int PHASE_COUNT     = 15;
    localparam int PHASE_ITEMS     = 96;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_LIMIT     = 2000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic [SAMPLE_W-1:0]   s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]      cfg_wr_data = '0;

    int                    fail_count;
    int                    pending_count;

    // Shared with the output side: random idling on or off, and a request for a long hold-off.
    logic                  gaps_on      = 1'b1;
    logic                  hold_off_req = 1'b0;

    // Window settings of the random phases; the last one is replaced by a random value.
    logic [CFG_W-1:0]      phase_widths [PHASE_COUNT] = '{
        7'd5, 7'd64, 7'd4, 7'd1, 7'd127, 7'd2, 7'd16, 7'd0,
        7'd63, 7'd7, 7'd3, 7'd32, 7'd8, 7'd100, 7'd9
    };

    always #5 clk = ~clk;

    sliding_window_median u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    median_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Offer one sample after an optional random gap; returns at the falling edge after the transfer.
    task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic restart);
        while (gaps_on && $urandom_range(99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Change the window only once every owed median is out and the row has settled.
    task automatic write_window(input logic [CFG_W-1:0] width);
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= width;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Many tiny values so duplicates and ties are common, some extremes, the rest full range.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return SAMPLE_W'($signed($urandom_range(8)) - 4);
        if (roll < 52)
        begin
            case ($urandom_range(4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h0000_0001;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom();
    endfunction

    // Output side: random stalls, with one long hold-off on request.
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_OFF_CYCLES; n++)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            m_tready <= !(gaps_on && $urandom_range(99) < 31);
        end
    end

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int p;
        int k;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Width three from reset: extremes, ties, and a restart on a full window.
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h0000_0005, 1'b0);
        send_item(32'h0000_0005, 1'b0);
        send_item(32'h0000_0005, 1'b0);
        send_item(32'hFFFF_FFF9, 1'b0);

        // Even width: largest and smallest sums of the two middle entries.
        write_window(7'd2);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0000, 1'b0);

        // Zero acts as one, and one passes samples through doubled.
        write_window(7'd0);
        send_item(32'h1234_5678, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        write_window(7'd1);
        send_item(32'hFFFF_FFFF, 1'b0);

        // Random phases over several window settings.
        phase_widths[PHASE_COUNT-1] = CFG_W'($urandom_range(1, 127));
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            write_window(phase_widths[p]);
            gaps_on = (p != 2);
            if (p == 3)
                hold_off_req = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
                send_item(pick_sample(), $urandom_range(99) < 2);
        end
        gaps_on = 1'b1;

        // Drain, then allow for the output register.
        s_tvalid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && pending_count != 0; k++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
design/swm_pkg.sv
design/swm_cell.sv
design/swm_history.sv
design/sliding_window_median.sv
tb/median_checker.sv
tb/sliding_window_median_tb.sv
